// ===== rtl/bmbt_pkg.sv =====
// ============================================================================
// bmbt_pkg
// Shared types and codes of the binary map border tracer.
// ============================================================================
package bmbt_pkg;

   localparam logic       OP_LOAD     = 1'b0;
   localparam logic       OP_NEXT     = 1'b1;

   localparam logic [1:0] KIND_LOAD   = 2'd0;
   localparam logic [1:0] KIND_VERTEX = 2'd1;
   localparam logic [1:0] KIND_NONE   = 2'd2;

   localparam logic [1:0] DIR_RIGHT   = 2'd0;
   localparam logic [1:0] DIR_DOWN    = 2'd1;
   localparam logic [1:0] DIR_LEFT    = 2'd2;
   localparam logic [1:0] DIR_UP      = 2'd3;

   localparam logic       CSR_WIDTH   = 1'b0;
   localparam logic       CSR_HEIGHT  = 1'b1;

   localparam int         CSR_DW      = 7;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_WAIT,
      ST_SCAN_DONE,
      ST_MARK_RD,
      ST_MARK_WR,
      ST_TRACE_RD,
      ST_TRACE_EVAL
   } state_type;

   typedef struct packed {
      logic load;
      logic scan_init;
      logic scan_rd;
      logic start_loop;
      logic mark_rd;
      logic mark_wr;
      logic trace_rd;
      logic trace_eval;
      logic rsp_none;
   } cmd_type;

   typedef struct packed {
      logic active;
      logic scan_last;
      logic found;
      logic closes;
   } sts_type;

endpackage

// ===== rtl/bmbt_ctrl.sv =====
// ============================================================================
// bmbt_ctrl
// Sequencer: loads, start-of-loop row scan, mark and trace-step phases.
// ============================================================================
module bmbt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              req_opcode,
   input  bmbt_pkg::sts_type sts,
   output bmbt_pkg::cmd_type cmd,
   output logic              busy
);

   bmbt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bmbt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bmbt_pkg::ST_IDLE: begin
            if (start && req_opcode == bmbt_pkg::OP_NEXT) begin
               state_in = sts.active ? bmbt_pkg::ST_MARK_WR : bmbt_pkg::ST_SCAN;
            end
         end
         bmbt_pkg::ST_SCAN: begin
            if (sts.scan_last) state_in = bmbt_pkg::ST_SCAN_WAIT;
         end
         bmbt_pkg::ST_SCAN_WAIT: state_in = bmbt_pkg::ST_SCAN_DONE;
         bmbt_pkg::ST_SCAN_DONE: begin
            state_in = sts.found ? bmbt_pkg::ST_MARK_RD : bmbt_pkg::ST_IDLE;
         end
         bmbt_pkg::ST_MARK_RD:   state_in = bmbt_pkg::ST_MARK_WR;
         bmbt_pkg::ST_MARK_WR: begin
            state_in = sts.closes ? bmbt_pkg::ST_IDLE : bmbt_pkg::ST_TRACE_RD;
         end
         bmbt_pkg::ST_TRACE_RD:   state_in = bmbt_pkg::ST_TRACE_EVAL;
         bmbt_pkg::ST_TRACE_EVAL: state_in = bmbt_pkg::ST_IDLE;
         default:                 state_in = bmbt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         bmbt_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               if (req_opcode == bmbt_pkg::OP_LOAD) begin
                  cmd.load = 1'b1;
               end else if (sts.active) begin
                  cmd.mark_rd = 1'b1;
               end else begin
                  cmd.scan_init = 1'b1;
               end
            end
         end
         bmbt_pkg::ST_SCAN:      cmd.scan_rd = 1'b1;
         bmbt_pkg::ST_SCAN_WAIT: ;
         bmbt_pkg::ST_SCAN_DONE: begin
            cmd.start_loop = sts.found;
            cmd.rsp_none   = !sts.found;
         end
         bmbt_pkg::ST_MARK_RD:    cmd.mark_rd    = 1'b1;
         bmbt_pkg::ST_MARK_WR:    cmd.mark_wr    = 1'b1;
         bmbt_pkg::ST_TRACE_RD:   cmd.trace_rd   = 1'b1;
         bmbt_pkg::ST_TRACE_EVAL: cmd.trace_eval = 1'b1;
         default: ;
      endcase
   end

endmodule

// ===== rtl/bmbt_dp.sv =====
// ============================================================================
// bmbt_dp
// Datapath: cell and used-mark memories, side evaluation, trace registers.
// ============================================================================
module bmbt_dp #(
   parameter int MAP_COLS = 64,
   parameter int MAP_ROWS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bmbt_pkg::cmd_type             cmd,
   output bmbt_pkg::sts_type             sts,
   input  logic [5:0]                    req_row_index,
   input  logic [63:0]                   req_row_bits,
   input  logic                          csr_wr_en,
   input  logic                          csr_index,
   input  logic [bmbt_pkg::CSR_DW-1:0]   csr_wdata,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_kind,
   output logic [6:0]                    rsp_vertex_x,
   output logic [6:0]                    rsp_vertex_y,
   output logic                          rsp_last_of_loop
);

   localparam int XW = $clog2(MAP_COLS + 1);
   localparam int YW = $clog2(MAP_ROWS + 1);
   localparam int RW = $clog2(MAP_ROWS);
   localparam int CW = $clog2(MAP_COLS);
   localparam int NV = MAP_COLS + 1;

   typedef logic [3:0][MAP_COLS-1:0] uword_type;

   // configuration
   logic [bmbt_pkg::CSR_DW-1:0] width_ff, height_ff;
   logic restart;

   assign restart = cmd.load || csr_wr_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 7'd64;
         height_ff <= 7'd64;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            bmbt_pkg::CSR_WIDTH:  width_ff  <= csr_wdata;
            bmbt_pkg::CSR_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // trace registers
   logic            active_ff;
   logic [XW-1:0]   pos_x_ff, ls_x_ff, end_x_ff, best_x_ff;
   logic [YW-1:0]   pos_y_ff, ls_y_ff, end_y_ff, best_y_ff;
   logic [1:0]      dir_ff, best_d_ff;
   logic            found_ff;
   logic [YW-1:0]   scan_y_ff, scan_qy_ff;
   logic            scan_q_vld_ff;

   // memories and per-row valid bits
   logic [MAP_COLS-1:0] cell_mem [MAP_ROWS];
   uword_type           used_mem [MAP_ROWS];
   logic [MAP_ROWS-1:0] cell_vld_ff, used_vld_ff;

   logic [MAP_COLS-1:0] cell_a_ff, cell_b_ff;
   uword_type           used_a_ff, used_b_ff;
   logic                ok_a_ff, ok_b_ff, uvld_a_ff, uvld_b_ff;

   logic [YW-1:0] rd_y, rd_ym1, mark_y;
   logic [RW-1:0] addr_a, addr_b, waddr, mark_row;
   logic          row_ok_a, row_ok_b, load_ok;
   logic [CW-1:0] mark_col;
   uword_type     mark_word;

   assign rd_y   = cmd.trace_rd ? end_y_ff : scan_y_ff;
   assign rd_ym1 = rd_y - YW'(1);
   assign mark_y = (dir_ff == bmbt_pkg::DIR_LEFT || dir_ff == bmbt_pkg::DIR_UP) ?
                   pos_y_ff - YW'(1) : pos_y_ff;
   assign mark_row = mark_y[RW-1:0];
   assign mark_col = (dir_ff == bmbt_pkg::DIR_DOWN || dir_ff == bmbt_pkg::DIR_LEFT) ?
                     CW'(pos_x_ff - XW'(1)) : CW'(pos_x_ff);
   assign addr_a = cmd.mark_rd ? mark_row : rd_ym1[RW-1:0];
   assign addr_b = rd_y[RW-1:0];
   assign row_ok_a = (rd_y != '0) && (rd_ym1 < height_ff);
   assign row_ok_b = (rd_y < height_ff) && (rd_y < YW'(MAP_ROWS));
   assign waddr   = RW'(req_row_index);
   assign load_ok = 32'(req_row_index) < MAP_ROWS;

   always_comb begin
      mark_word = uvld_a_ff ? used_a_ff : '0;
      mark_word[dir_ff][mark_col] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.load && load_ok) cell_mem[waddr] <= req_row_bits[MAP_COLS-1:0];
      cell_a_ff <= cell_mem[addr_a];
      cell_b_ff <= cell_mem[addr_b];
      ok_a_ff   <= row_ok_a && cell_vld_ff[addr_a];
      ok_b_ff   <= row_ok_b && cell_vld_ff[addr_b];
   end

   always_ff @(posedge clock) begin
      if (cmd.mark_wr) used_mem[mark_row] <= mark_word;
      used_a_ff <= used_mem[addr_a];
      used_b_ff <= used_mem[addr_b];
      uvld_a_ff <= used_vld_ff[addr_a];
      uvld_b_ff <= used_vld_ff[addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_vld_ff <= '0;
         used_vld_ff <= '0;
      end else begin
         if (cmd.load && load_ok) cell_vld_ff[waddr] <= 1'b1;
         if (restart) begin
            used_vld_ff <= '0;
         end else if (cmd.mark_wr) begin
            used_vld_ff[mark_row] <= 1'b1;
         end
      end
   end

   // free sides leaving each vertex of the row between the two rows read
   logic [MAP_COLS-1:0] wmask, up, lo;
   uword_type           ua, ub;
   logic [3:0][NV-1:0]  cand;
   logic                ca, cb, cc, ce;

   always_comb begin
      for (int i = 0; i < MAP_COLS; i++) wmask[i] = i < 32'(width_ff);
      up = ok_a_ff ? (cell_a_ff & wmask) : '0;
      lo = ok_b_ff ? (cell_b_ff & wmask) : '0;
      ua = uvld_a_ff ? used_a_ff : '0;
      ub = uvld_b_ff ? used_b_ff : '0;
      cand = '0;
      for (int x = 0; x < NV; x++) begin
         ca = 1'b0; cb = 1'b0; cc = 1'b0; ce = 1'b0;
         if (x > 0) begin
            ca = up[x-1];
            cc = lo[x-1];
         end
         if (x < MAP_COLS) begin
            cb = up[x];
            ce = lo[x];
         end
         if (x < MAP_COLS) begin
            cand[bmbt_pkg::DIR_RIGHT][x] = ce && !cb && !ub[bmbt_pkg::DIR_RIGHT][x];
            cand[bmbt_pkg::DIR_UP][x]    = cb && !ca && !ua[bmbt_pkg::DIR_UP][x];
         end
         if (x > 0) begin
            cand[bmbt_pkg::DIR_DOWN][x]  = cc && !ce && !ub[bmbt_pkg::DIR_DOWN][x-1];
            cand[bmbt_pkg::DIR_LEFT][x]  = ca && !cc && !ua[bmbt_pkg::DIR_LEFT][x-1];
         end
      end
   end

   // lowest vertex x with a free side, then left, up, down, right
   logic [NV-1:0] any_side;
   logic [XW-1:0] row_x;
   logic [1:0]    row_d;
   logic          row_hit;

   always_comb begin
      any_side = cand[0] | cand[1] | cand[2] | cand[3];
      row_hit  = |any_side;
      row_x    = '0;
      for (int x = NV - 1; x >= 0; x--) begin
         if (any_side[x]) row_x = XW'(x);
      end
      if (cand[bmbt_pkg::DIR_LEFT][row_x])      row_d = bmbt_pkg::DIR_LEFT;
      else if (cand[bmbt_pkg::DIR_UP][row_x])   row_d = bmbt_pkg::DIR_UP;
      else if (cand[bmbt_pkg::DIR_DOWN][row_x]) row_d = bmbt_pkg::DIR_DOWN;
      else                                      row_d = bmbt_pkg::DIR_RIGHT;
   end

   // end vertex of the side being walked
   logic [XW-1:0] end_x_c;
   logic [YW-1:0] end_y_c;
   logic          closes;

   always_comb begin
      end_x_c = pos_x_ff;
      end_y_c = pos_y_ff;
      case (dir_ff)
         bmbt_pkg::DIR_RIGHT: end_x_c = pos_x_ff + XW'(1);
         bmbt_pkg::DIR_DOWN:  end_y_c = pos_y_ff + YW'(1);
         bmbt_pkg::DIR_LEFT:  end_x_c = pos_x_ff - XW'(1);
         default:             end_y_c = pos_y_ff - YW'(1);
      endcase
      closes = (end_x_c == ls_x_ff) && (end_y_c == ls_y_ff);
   end

   // left turn, straight on, right turn
   logic [1:0] turn_l, turn_r, next_d;
   logic       next_ok;

   always_comb begin
      turn_l  = dir_ff + 2'd3;
      turn_r  = dir_ff + 2'd1;
      next_ok = 1'b1;
      if (cand[turn_l][end_x_ff])      next_d = turn_l;
      else if (cand[dir_ff][end_x_ff]) next_d = dir_ff;
      else if (cand[turn_r][end_x_ff]) next_d = turn_r;
      else begin
         next_d  = dir_ff;
         next_ok = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         found_ff      <= 1'b0;
         scan_q_vld_ff <= 1'b0;
         scan_y_ff     <= '0;
         pos_x_ff      <= '0;
         pos_y_ff      <= '0;
         ls_x_ff       <= '0;
         ls_y_ff       <= '0;
         dir_ff        <= '0;
      end else begin
         scan_q_vld_ff <= cmd.scan_rd;
         if (cmd.scan_init) begin
            scan_y_ff <= '0;
            found_ff  <= 1'b0;
         end
         if (cmd.scan_rd) scan_y_ff <= scan_y_ff + YW'(1);
         if (scan_q_vld_ff && row_hit && (!found_ff || row_x < best_x_ff)) begin
            found_ff <= 1'b1;
         end
         if (cmd.start_loop) begin
            active_ff <= 1'b1;
            pos_x_ff  <= best_x_ff;
            pos_y_ff  <= best_y_ff;
            ls_x_ff   <= best_x_ff;
            ls_y_ff   <= best_y_ff;
            dir_ff    <= best_d_ff;
         end
         if (cmd.mark_wr && closes) active_ff <= 1'b0;
         if (cmd.trace_eval) begin
            if (next_ok) begin
               pos_x_ff <= end_x_ff;
               pos_y_ff <= end_y_ff;
               dir_ff   <= next_d;
            end else begin
               active_ff <= 1'b0;
            end
         end
         if (restart) active_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      scan_qy_ff <= scan_y_ff;
      if (scan_q_vld_ff && row_hit && (!found_ff || row_x < best_x_ff)) begin
         best_x_ff <= row_x;
         best_y_ff <= scan_qy_ff;
         best_d_ff <= row_d;
      end
      if (cmd.mark_wr) begin
         end_x_ff <= end_x_c;
         end_y_ff <= end_y_c;
      end
   end

   // result beat
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] kind_ff, kind_in;
   logic [6:0] vx_ff, vx_in, vy_ff, vy_in;
   logic       last_ff, last_in;

   always_comb begin
      rsp_valid_in = 1'b0;
      kind_in      = bmbt_pkg::KIND_LOAD;
      vx_in        = '0;
      vy_in        = '0;
      last_in      = 1'b0;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (cmd.rsp_none) begin
         rsp_valid_in = 1'b1;
         kind_in      = bmbt_pkg::KIND_NONE;
      end else if ((cmd.mark_wr && closes) || cmd.trace_eval) begin
         rsp_valid_in = 1'b1;
         kind_in      = bmbt_pkg::KIND_VERTEX;
         vx_in        = 7'(pos_x_ff);
         vy_in        = 7'(pos_y_ff);
         last_in      = cmd.mark_wr || !next_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff <= kind_in;
      vx_ff   <= vx_in;
      vy_ff   <= vy_in;
      last_ff <= last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_vertex_x     = vx_ff;
   assign rsp_vertex_y     = vy_ff;
   assign rsp_last_of_loop = last_ff;

   assign sts.active    = active_ff;
   assign sts.scan_last = scan_y_ff == YW'(MAP_ROWS);
   assign sts.found     = found_ff;
   assign sts.closes    = closes;

endmodule

// ===== rtl/binary_map_border_tracer.sv =====
// ============================================================================
// binary_map_border_tracer
// Loads map rows and returns one border vertex, or none, per next request.
// ============================================================================
//  channel   ports                                          handshake
//  request   req_opcode, req_row_index, req_row_bits        start && !busy
//  result    rsp_kind, rsp_vertex_x/y, rsp_last_of_loop     rsp_valid, 1 cycle
//  csr       csr_index, csr_wdata                           csr_wr_en
//
// A load's beat shows the next cycle. A next request inside an open loop runs
// a mark read-modify-write, then a two-row read of both memories and the turn
// choice; a step that closes its loop ends after the mark write. Opening a loop
// first scans MAP_ROWS+1 vertex rows, one per cycle through a priority encoder.
// Reset is synchronous and leaves cells and marks clear; beats cannot be held
// off, so busy stays high until a beat is issued.
module binary_map_border_tracer #(
   parameter int MAP_COLS = 64,
   parameter int MAP_ROWS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_opcode,
   input  logic [5:0]                  req_row_index,
   input  logic [63:0]                 req_row_bits,
   output logic                        rsp_valid,
   output logic [1:0]                  rsp_kind,
   output logic [6:0]                  rsp_vertex_x,
   output logic [6:0]                  rsp_vertex_y,
   output logic                        rsp_last_of_loop,
   input  logic                        csr_wr_en,
   input  logic                        csr_index,
   input  logic [bmbt_pkg::CSR_DW-1:0] csr_wdata
);

   bmbt_pkg::cmd_type cmd;
   bmbt_pkg::sts_type sts;

   bmbt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .sts        (sts),
      .cmd        (cmd),
      .busy       (busy)
   );

   bmbt_dp #(
      .MAP_COLS (MAP_COLS),
      .MAP_ROWS (MAP_ROWS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_row_index    (req_row_index),
      .req_row_bits     (req_row_bits),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_kind         (rsp_kind),
      .rsp_vertex_x     (rsp_vertex_x),
      .rsp_vertex_y     (rsp_vertex_y),
      .rsp_last_of_loop (rsp_last_of_loop)
   );

endmodule

// ===== rtl/bmbt_checker.sv =====
// ============================================================================
// bmbt_checker
// Port-level checks of the border tracer, bound to the top level.
// ============================================================================
module bmbt_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       req_opcode,
   input logic       rsp_valid,
   input logic [1:0] rsp_kind,
   input logic [6:0] rsp_vertex_x,
   input logic [6:0] rsp_vertex_y,
   input logic       rsp_last_of_loop
);

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == bmbt_pkg::KIND_LOAD || rsp_kind == bmbt_pkg::KIND_VERTEX ||
                     rsp_kind == bmbt_pkg::KIND_NONE))
      else $error("illegal result kind");

   a_non_vertex_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != bmbt_pkg::KIND_VERTEX) |->
         (rsp_vertex_x == 7'd0 && rsp_vertex_y == 7'd0 && !rsp_last_of_loop))
      else $error("non-vertex beat carries vertex data");

   a_load_ack: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_opcode == bmbt_pkg::OP_LOAD) |=>
         (rsp_valid && rsp_kind == bmbt_pkg::KIND_LOAD))
      else $error("load not acknowledged next cycle");

   a_next_after_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != bmbt_pkg::KIND_LOAD) |-> $past(busy))
      else $error("trace beat without busy phase");

endmodule

bind binary_map_border_tracer bmbt_checker u_bmbt_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_opcode       (req_opcode),
   .rsp_valid        (rsp_valid),
   .rsp_kind         (rsp_kind),
   .rsp_vertex_x     (rsp_vertex_x),
   .rsp_vertex_y     (rsp_vertex_y),
   .rsp_last_of_loop (rsp_last_of_loop)
);
